/* rtl/core/indexed_deque_list_assert.svh */
// Assertion macros used by the checker file of the ordered list block.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef INDEXED_DEQUE_LIST_ASSERT_SVH
`define INDEXED_DEQUE_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IDL_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IDL_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/idl_pkg.sv */
// Package for the ordered list block: sizes, request and status codes, beat types.
// Used by the interfaces, the sequencer, the top level and the checker.
`timescale 1ns / 1ps

package idl_pkg;

    // Storage sizes.
    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 8;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One request beat.
    typedef struct packed {
        logic [1:0]             req_type;
        logic [POS_W-1:0]       position;
        logic [VALUE_WIDTH-1:0] value_in;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value_out;
        logic [1:0]             status;
        logic [CNT_W-1:0]       count;
        logic [VALUE_WIDTH-1:0] front_value;
        logic [VALUE_WIDTH-1:0] back_value;
    } t_result;

    // One access to the entry store.
    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]      raddr;
    } t_ram_req;

endpackage

/* rtl/core/idl_if.sv */
// Valid/ready channel interfaces for the request and result beats.
// Depends on idl_pkg for field widths.
`timescale 1ns / 1ps

interface idl_req_if;
    import idl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             req_type;
    logic [POS_W-1:0]       position;
    logic [VALUE_WIDTH-1:0] value_in;

    modport source (output valid, req_type, position, value_in, input ready);
    modport sink   (input valid, req_type, position, value_in, output ready);
    modport mon    (input valid, ready, req_type, position, value_in);
endinterface

interface idl_rsp_if;
    import idl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [1:0]             status;
    logic [CNT_W-1:0]       count;
    logic [VALUE_WIDTH-1:0] front_value;
    logic [VALUE_WIDTH-1:0] back_value;

    modport source (output valid, value_out, status, count, front_value, back_value,
                    input ready);
    modport sink   (input valid, value_out, status, count, front_value, back_value,
                    output ready);
    modport mon    (input valid, ready, value_out, status, count, front_value,
                    back_value);
endinterface

/* rtl/core/idl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; contents are undefined until written.
`timescale 1ns / 1ps

module idl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/idl_ctrl.sv */
// Sequencer of the ordered list: walks the entry store one move at a time to
// insert, remove and read back the ends. Depends on idl_pkg and drives idl_ram.
`timescale 1ns / 1ps

module idl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  idl_pkg::t_req                 i_req,
    input  logic                          i_slot_free,
    input  logic [idl_pkg::VALUE_WIDTH-1:0] i_rd_data,
    output idl_pkg::t_ram_req             o_ram,
    output logic                          o_idle,
    output logic                          o_done,
    output idl_pkg::t_result              o_result
);
    import idl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SH_RD  = 9'b000000010,
        S_SH_WR  = 9'b000000100,
        S_RM_RD  = 9'b000001000,
        S_RM_CAP = 9'b000010000,
        S_FRONT  = 9'b000100000,
        S_BACK   = 9'b001000000,
        S_TAIL   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_is_ins, n_is_ins;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [VALUE_WIDTH-1:0] r_value_out, n_value_out;
    logic [1:0]             r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_front, n_front;
    logic [VALUE_WIDTH-1:0] r_back, n_back;

    logic [CNT_W-1:0] w_idx_dn;
    logic [CNT_W-1:0] w_idx_up;
    logic [CNT_W-1:0] w_cnt_dn;
    logic [CMP_W-1:0] w_pos_ext;
    logic [CNT_W-1:0] w_ins_pos;
    logic [CNT_W-1:0] w_rm_pos;

    // Neighbor indexes and clamped positions.
    assign w_idx_dn  = r_idx - CNT_W'(1);
    assign w_idx_up  = r_idx + CNT_W'(1);
    assign w_cnt_dn  = r_cnt - CNT_W'(1);
    assign w_pos_ext = CMP_W'(i_req.position);
    assign w_ins_pos = (w_pos_ext > CMP_W'(r_cnt)) ? r_cnt : CNT_W'(w_pos_ext);
    assign w_rm_pos  = (w_pos_ext >= CMP_W'(w_cnt_dn)) ? w_cnt_dn : CNT_W'(w_pos_ext);

    // Next-state logic: one store access per cycle.
    always_comb begin
        n_state     = r_state;
        n_is_ins    = r_is_ins;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_value_out = r_value_out;
        n_status    = r_status;
        n_front     = r_front;
        n_back      = r_back;
        o_ram       = '0;
        o_done      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val       = i_req.value_in;
                    n_value_out = '0;
                    n_status    = ST_OK;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_FRONT;
                            end else begin
                                n_is_ins = 1'b1;
                                n_idx    = r_cnt;
                                n_pos    = w_ins_pos;
                                n_state  = S_SH_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FRONT;
                            end else begin
                                n_is_ins = 1'b0;
                                n_pos    = w_rm_pos;
                                n_state  = S_RM_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_FRONT;
                        end
                        default: begin
                            n_state = S_FRONT;
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                // Either fetch the next entry to move or finish the command.
                if (r_is_ins) begin
                    if (r_idx > r_pos) begin
                        o_ram.raddr = w_idx_dn[ADDR_W-1:0];
                        n_state     = S_SH_WR;
                    end else begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_pos[ADDR_W-1:0];
                        o_ram.wdata = r_val;
                        n_cnt       = r_cnt + CNT_W'(1);
                        n_state     = S_FRONT;
                    end
                end else begin
                    if (w_idx_up < r_cnt) begin
                        o_ram.raddr = w_idx_up[ADDR_W-1:0];
                        n_state     = S_SH_WR;
                    end else begin
                        n_cnt   = w_cnt_dn;
                        n_state = S_FRONT;
                    end
                end
            end
            S_SH_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[ADDR_W-1:0];
                o_ram.wdata = i_rd_data;
                n_idx       = r_is_ins ? w_idx_dn : w_idx_up;
                n_state     = S_SH_RD;
            end
            S_RM_RD: begin
                o_ram.raddr = r_pos[ADDR_W-1:0];
                n_state     = S_RM_CAP;
            end
            S_RM_CAP: begin
                n_value_out = i_rd_data;
                n_idx       = r_pos;
                n_state     = S_SH_RD;
            end
            S_FRONT: begin
                if (r_cnt == '0) begin
                    n_front = '0;
                    n_back  = '0;
                    n_state = S_DONE;
                end else begin
                    o_ram.raddr = '0;
                    n_state     = S_BACK;
                end
            end
            S_BACK: begin
                n_front     = i_rd_data;
                o_ram.raddr = w_cnt_dn[ADDR_W-1:0];
                n_state     = S_TAIL;
            end
            S_TAIL: begin
                n_back  = i_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; working values are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_is_ins    <= n_is_ins;
        r_pos       <= n_pos;
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_value_out <= n_value_out;
        r_status    <= n_status;
        r_front     <= n_front;
        r_back      <= n_back;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_result = '{value_out:   r_value_out,
                        status:      r_status,
                        count:       r_cnt,
                        front_value: r_front,
                        back_value:  r_back};

endmodule

/* rtl/core/indexed_deque_list.sv */
// Ordered list with indexed insert and remove: top level with the result register.
// Depends on idl_pkg, idl_if, idl_ram and idl_ctrl.
//
// Usage:
//   i_req carries one command per beat: insert value_in at position, remove the
//   entry at position, or clear. Positions past the end clamp to the back.
//   o_rsp returns one beat per command with the removed value, status, new
//   count and the front and back values (zero when the list is empty).
//   Commands are taken one at a time; i_req.ready is high only while the
//   sequencer is idle, even if a result still waits in the output register.
//   An insert moves the entries from the position to the back up one place,
//   then writes the new value; a remove reads the entry at the position, then
//   moves the entries behind it down one place. A refused insert, an empty
//   remove, a clear or the unused code moves no entries. The ends are then
//   read back unless the list is empty. The next command can be taken in the
//   same cycle as the result turns valid. Each moved entry is read from the
//   registered-read store and then written back, and the ends are read back
//   one per cycle. Reset empties the list at once; no clearing pass is
//   needed. If the receiver stalls, the result is held and the next command
//   may still be taken, but its result waits until the output register frees up.
`timescale 1ns / 1ps

module indexed_deque_list (
    input  logic    i_clk,
    input  logic    i_rst_n,
    idl_req_if.sink   i_req,
    idl_rsp_if.source o_rsp
);
    import idl_pkg::*;

    t_req                   w_req;
    t_ram_req               w_ram;
    t_result                w_result;
    logic [VALUE_WIDTH-1:0] w_rd_data;
    logic                   w_idle;
    logic                   w_done;
    logic                   w_start;
    logic                   w_slot_free;
    logic                   r_out_valid;
    t_result                r_out;

    // Request handshake.
    assign w_req       = '{req_type: i_req.req_type, position: i_req.position,
                           value_in: i_req.value_in};
    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    idl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_req       (w_req),
        .i_slot_free (w_slot_free),
        .i_rd_data   (w_rd_data),
        .o_ram       (w_ram),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_result    (w_result)
    );

    idl_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    // Output register holds a result beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value_out   = r_out.value_out;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.count       = r_out.count;
    assign o_rsp.front_value = r_out.front_value;
    assign o_rsp.back_value  = r_out.back_value;

endmodule

/* rtl/core/idl_chk.sv */
// Port-level checker for the ordered list, bound to the top level.
// Depends on idl_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "indexed_deque_list_assert.svh"

module idl_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [idl_pkg::VALUE_WIDTH-1:0] i_value_out,
    input logic [1:0]                      i_status,
    input logic [idl_pkg::CNT_W-1:0]       i_count,
    input logic [idl_pkg::VALUE_WIDTH-1:0] i_front_value,
    input logic [idl_pkg::VALUE_WIDTH-1:0] i_back_value
);
    import idl_pkg::*;

    logic          w_rsp_stall;
    logic          w_rsp_full;
    logic          w_rsp_empty;
    logic          w_rsp_none;
    t_result       w_rsp_beat;

    // Conditions seen on the result channel.
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign w_rsp_full  = i_rsp_valid && (i_status == ST_FULL);
    assign w_rsp_empty = i_rsp_valid && (i_status == ST_EMPTY);
    assign w_rsp_none  = i_rsp_valid && (i_count == '0);
    assign w_rsp_beat  = '{value_out:   i_value_out,
                           status:      i_status,
                           count:       i_count,
                           front_value: i_front_value,
                           back_value:  i_back_value};

    // A stalled result beat keeps its payload.
    `IDL_CHECK_NEXT(a_rsp_hold, w_rsp_stall, i_rsp_valid && $stable(w_rsp_beat), "held beat changed")

    // The block is busy for at least the cycle after a request beat.
    `IDL_CHECK_NEXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready, "busy cycle missing")

    // A refused insert reports a full list.
    `IDL_CHECK(a_full_count, w_rsp_full, i_count == CNT_W'(DEPTH), "full status, list not full")

    // An empty remove reports an empty list and no value.
    `IDL_CHECK(a_empty_rsp, w_rsp_empty, i_count == '0 && i_value_out == '0, "bad empty result")

    // An empty list shows zero at both ends.
    `IDL_CHECK(a_empty_ends, w_rsp_none, i_front_value == '0 && i_back_value == '0, "bad empty ends")

endmodule

bind indexed_deque_list idl_chk u_idl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_value_out   (o_rsp.value_out),
    .i_status      (o_rsp.status),
    .i_count       (o_rsp.count),
    .i_front_value (o_rsp.front_value),
    .i_back_value  (o_rsp.back_value)
);
